/* rtl/dhj_pkg.sv */
// Shared types and constants for the DH chain Jacobian block.
// Used by dhj_cordic, dhj_mac and dh_chain_jacobian; no dependencies.
package dhj_pkg;

  localparam int DW           = 32;   // matrix entry width, Q20
  localparam int TW           = 24;   // CORDIC datapath width
  localparam int ACW          = 64;   // product / accumulator width
  localparam int FRAC         = 20;
  localparam int CORDIC_STEPS = 20;
  localparam int NCOLS        = 7;
  localparam int NROWS        = 6;

  localparam logic signed [TW-1:0] CORDIC_GAIN = 24'sd636751;
  localparam logic signed [TW-1:0] PI_Q20      = 24'sd3294199;
  localparam logic signed [TW-1:0] HALF_PI_Q20 = 24'sd1647099;

  localparam logic signed [DW-1:0]  ONE_Q20  = 32'sd1048576;
  localparam logic signed [DW-1:0]  OUT_MAX  = 32'sd8388607;
  localparam logic signed [DW-1:0]  OUT_MIN  = -32'sd8388608;
  localparam logic signed [ACW-1:0] HALF_LSB = 64'sd524288;

  typedef enum logic [3:0] {
    S_IDLE, S_TH_GO, S_TH_WAIT, S_AL_GO, S_AL_WAIT, S_BP, S_BW,
    S_CMP, S_SKW, S_DRAIN, S_COL, S_EMIT
  } state_t;

  typedef enum logic [1:0] {MD_BUILD, MD_COMP, MD_SKEW} mode_t;

  typedef struct packed {
    mode_t      md;
    logic       first;
    logic       last;
    logic [1:0] r;
    logic [1:0] c;
    logic [2:0] e;
    logic       ecap;
  } tag_t;

  function automatic logic signed [TW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [TW-1:0] v;
    case (idx)
      5'd0:  v = 24'sd823550;
      5'd1:  v = 24'sd486170;
      5'd2:  v = 24'sd256879;
      5'd3:  v = 24'sd130396;
      5'd4:  v = 24'sd65451;
      5'd5:  v = 24'sd32757;
      5'd6:  v = 24'sd16383;
      5'd7:  v = 24'sd8192;
      5'd8:  v = 24'sd4096;
      5'd9:  v = 24'sd2048;
      5'd10: v = 24'sd1024;
      5'd11: v = 24'sd512;
      5'd12: v = 24'sd256;
      5'd13: v = 24'sd128;
      5'd14: v = 24'sd64;
      5'd15: v = 24'sd32;
      5'd16: v = 24'sd16;
      5'd17: v = 24'sd8;
      5'd18: v = 24'sd4;
      5'd19: v = 24'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/dhj_cordic.sv */
// Iterative rotation-mode CORDIC: sine and cosine of a Q15 angle, Q20 out.
// One micro-rotation per cycle. Depends on dhj_pkg.
module dhj_cordic import dhj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic signed [17:0]   ang,
  output logic                 done,
  output logic signed [TW-1:0] sin_v,
  output logic signed [TW-1:0] cos_v
);

  logic signed [TW-1:0] x, y, z, z0, dx, dy, at;
  logic                 neg, run;
  logic [4:0]           step;

  always_comb begin
    z0 = TW'({{(TW-18){ang[17]}}, ang} << 5);
    dx = y >>> step;
    dy = x >>> step;
    at = atan_lut(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        step <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        if (z0 > HALF_PI_Q20) begin
          z   <= z0 - PI_Q20;
          neg <= 1'b1;
        end else if (z0 < -HALF_PI_Q20) begin
          z   <= z0 + PI_Q20;
          neg <= 1'b1;
        end else begin
          z   <= z0;
          neg <= 1'b0;
        end
      end else if (run) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (step == 5'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

  assign sin_v = neg ? -y : y;
  assign cos_v = neg ? -x : x;

endmodule

/* rtl/dhj_mac.sv */
// Shared multiply-accumulate unit: registered 32x32 product, then
// accumulate with Q20 round-half-up of the running sum. Depends on dhj_pkg.
module dhj_mac import dhj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_v,
  input  logic                 in_first,
  input  logic signed [DW-1:0] opa,
  input  logic signed [DW-1:0] opb,
  output logic                 out_v,
  output logic signed [DW-1:0] rnd_v
);

  logic signed [ACW-1:0] prod, acc, sum, tmp;
  logic                  pv, pfirst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= ACW'(opa) * ACW'(opb);
    pfirst <= in_first;
    if (pv) begin
      acc <= sum;
    end
  end

  always_comb begin
    sum   = (pfirst ? '0 : acc) + prod;
    tmp   = (sum + HALF_LSB) >>> FRAC;
    rnd_v = DW'(tmp);
  end

  assign out_v = pv;

endmodule

/* rtl/dh_chain_jacobian.sv */
// Geometric Jacobian of a modified-DH serial chain: top level, sequencer,
// link storage and matrix banks. Depends on dhj_pkg, dhj_cordic, dhj_mac.
//
// Usage:
//  - Links arrive one per request: present joint_angle, link_length,
//    link_offset, link_twist and last_link with start high; the request is
//    taken on a rising edge with start high and busy low.
//  - A request without last_link is stored and busy stays low, so links can
//    be sent on consecutive cycles. Links beyond MAX_LINKS are dropped.
//  - A request with last_link raises busy on the next cycle and runs the
//    whole chain: per link two CORDIC runs and six products, then matrix
//    chains: the plain one for the end rotation, one per live column.
//  - Results: 42 entries in column-major order, the six of a column on
//    consecutive cycles, each shown for exactly one cycle with strobe high;
//    last_entry marks the 42nd. The receiver cannot stall; nothing is held.
//  - Run for n links: link setup (two CORDIC runs, product issues, drain
//    and writes), then matrix composes on the shared multiplier (terms
//    plus drain), n*(1+min(n,JOINTS)) composes in all, then skew terms
//    and output per live column (output only for an absent joint). The
//    single multiplier (one term per cycle) sets the run time.
//  - Reset: synchronous, clears the link count and sequencer; stored links
//    are lost and no results come out of a run that reset cuts off.
module dh_chain_jacobian import dhj_pkg::*; #(
  parameter int MAX_LINKS = 8,
  parameter int JOINTS    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [17:0] joint_angle,
  input  logic signed [17:0] link_length,
  input  logic signed [17:0] link_offset,
  input  logic signed [17:0] link_twist,
  input  logic               last_link,
  output logic               strobe,
  output logic [2:0]         row_index,
  output logic [2:0]         column_index,
  output logic signed [23:0] entry_value,
  output logic               last_entry
);

  localparam int LW  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int CW  = $clog2(MAX_LINKS + 1);
  localparam int LMD = MAX_LINKS * 16;

  state_t state, state_next;

  // link parameter stores: {a, d} and {alpha, theta}
  logic [35:0] la_mem [MAX_LINKS];
  logic [35:0] lt_mem [MAX_LINKS];

  // link transforms, entry {link, row, col}
  logic signed [DW-1:0] lm [LMD];
  logic signed [DW-1:0] rd;

  // running product, two banks of 3x4
  logic signed [DW-1:0] pm [32];
  logic signed [DW-1:0] em [9];
  logic signed [DW-1:0] bp [6];
  logic signed [DW-1:0] sk [3];

  logic [CW-1:0] cnt, n, ci, li;
  logic [2:0]    jc, er, be;
  logic [1:0]    ir, ic, ik;
  logic          bank, pid, first, zcol;
  logic          accept, cnt_full, cgo, iss;
  mode_t         imode, dmode;

  logic signed [DW-1:0] s_r, c_r, sa_r, ca_r, a_q, d_q;
  logic signed [17:0]   th_v, cang;
  logic                 cdone;
  logic signed [TW-1:0] csin, ccos;

  logic                 deriv, klast_hit, cmp_end, skw_end, col_ok;
  logic [1:0]           cmap, prow, erow, klast;
  logic [4:0]           pm_ra;
  logic [3:0]           emi;
  logic [LW+3:0]        lm_ra, lm_wa;
  logic                 lm_we;
  logic signed [DW-1:0] lm_wd, pm_rd, a_v, b_v, ev;
  logic                 b_mem, b_neg;
  tag_t                 tg, t1, t2;

  // pipeline stage 1
  logic                 v1, bmem1, bneg1;
  logic signed [DW-1:0] opa1, opb1, bval;
  logic                 pv;
  logic signed [DW-1:0] rv;

  assign accept   = start && !busy;
  assign cnt_full = (cnt == CW'(MAX_LINKS));

  // ---------------- link fields ----------------
  always_comb begin
    a_q  = {{(DW-22){la_mem[ci[LW-1:0]][35]}}, la_mem[ci[LW-1:0]][35:18], 4'b0};
    d_q  = {{(DW-22){la_mem[ci[LW-1:0]][17]}}, la_mem[ci[LW-1:0]][17:0], 4'b0};
    th_v = (int'(ci) < JOINTS) ? lt_mem[ci[LW-1:0]][17:0] : '0;
    cang = (state == S_AL_GO) ? lt_mem[ci[LW-1:0]][35:18] : th_v;
  end

  dhj_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .go    (cgo),
    .ang   (cang),
    .done  (cdone),
    .sin_v (csin),
    .cos_v (ccos)
  );

  // ---------------- issue-side decode ----------------
  always_comb begin
    deriv     = !first && (int'(li) == int'(jc));
    klast     = (ic == 2'd3) ? 2'd3 : 2'd2;
    klast_hit = (ik == klast);
    cmp_end   = (ir == 2'd2) && (ic == 2'd3) && (ik == 2'd3);
    skw_end   = (ir == 2'd2) && (ik == 2'd2);
    col_ok    = (int'(jc) < int'(n)) && (int'(jc) < JOINTS);
    cmap      = deriv ? ((ic == 2'd0) ? 2'd1 : 2'd0) : ic;
    lm_ra     = {li[LW-1:0], ik, cmap};
    // skew rows: W21, W02, W10
    case (ir)
      2'd0:    begin prow = 2'd2; erow = 2'd1; end
      2'd1:    begin prow = 2'd0; erow = 2'd2; end
      default: begin prow = 2'd1; erow = 2'd0; end
    endcase
    emi = {2'b0, erow} * 4'd3 + {2'b0, ik};
    case (state)
      S_SKW:   pm_ra = {bank, prow, ik};
      S_EMIT:  pm_ra = {bank, er[1:0], 2'd3};
      default: pm_ra = {bank, ir, ik};
    endcase
    pm_rd = pm[pm_ra];
    case (state)
      S_BP:    imode = MD_BUILD;
      S_CMP:   imode = MD_COMP;
      default: imode = MD_SKEW;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    a_v   = '0;
    b_v   = '0;
    b_mem = 1'b0;
    b_neg = 1'b0;
    case (imode)
      MD_BUILD: begin
        case (be)
          3'd0, 3'd3: a_v = s_r;
          3'd1, 3'd4: a_v = c_r;
          default:    a_v = d_q;
        endcase
        case (be)
          3'd2, 3'd3, 3'd4: b_v = sa_r;
          default:          b_v = ca_r;
        endcase
      end
      MD_COMP: begin
        if (pid) begin
          a_v = ({ik} == {ir}) ? ONE_Q20 : '0;
        end else begin
          a_v = pm_rd;
        end
        if (ik == 2'd3) begin
          // translation carry-through scaled by the link's w
          b_v = deriv ? '0 : ONE_Q20;
        end else if (deriv && ic[1]) begin
          b_v = '0;
        end else begin
          b_mem = 1'b1;
          b_neg = deriv && (ic == 2'd1);
        end
      end
      default: begin
        a_v = pm_rd;
        b_v = em[emi];
      end
    endcase
    tg.md    = imode;
    tg.first = (imode == MD_BUILD) || (ik == 2'd0);
    case (imode)
      MD_BUILD: tg.last = 1'b1;
      MD_COMP:  tg.last = klast_hit;
      default:  tg.last = (ik == 2'd2);
    endcase
    tg.r    = ir;
    tg.c    = ic;
    tg.e    = be;
    tg.ecap = first && ((li + 1'b1) == n) && (ic != 2'd3);
  end

  // ---------------- link transform memory ----------------
  always_comb begin
    lm_we = (state == S_BW);
    lm_wa = {ci[LW-1:0], ir, ic};
    case ({ir, ic})
      4'd0:    lm_wd = c_r;
      4'd1:    lm_wd = -s_r;
      4'd3:    lm_wd = a_q;
      4'd4:    lm_wd = bp[0];
      4'd5:    lm_wd = bp[1];
      4'd6:    lm_wd = -sa_r;
      4'd7:    lm_wd = -bp[2];
      4'd8:    lm_wd = bp[3];
      4'd9:    lm_wd = bp[4];
      4'd10:   lm_wd = ca_r;
      4'd11:   lm_wd = bp[5];
      default: lm_wd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lm[lm_wa] <= lm_wd;
    end
    rd <= lm[lm_ra];
  end

  // ---------------- MAC pipeline ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= iss;
    end
    opa1  <= a_v;
    opb1  <= b_v;
    bmem1 <= b_mem;
    bneg1 <= b_neg;
    t1    <= tg;
    t2    <= t1;
  end

  assign bval = bmem1 ? (bneg1 ? -rd : rd) : opb1;

  dhj_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_v     (v1),
    .in_first (t1.first),
    .opa      (opa1),
    .opb      (bval),
    .out_v    (pv),
    .rnd_v    (rv)
  );

  // result write-back
  always_ff @(posedge clk) begin
    if (pv && t2.last) begin
      case (t2.md)
        MD_BUILD: bp[t2.e] <= rv;
        MD_COMP: begin
          pm[{~bank, t2.r, t2.c}] <= rv;
          if (t2.ecap) begin
            em[{2'b0, t2.r} * 4'd3 + {2'b0, t2.c}] <= rv;
          end
        end
        default:  sk[t2.r] <= rv;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (accept && last_link) state_next = S_TH_GO;
      S_TH_GO:   state_next = S_TH_WAIT;
      S_TH_WAIT: if (cdone) state_next = S_AL_GO;
      S_AL_GO:   state_next = S_AL_WAIT;
      S_AL_WAIT: if (cdone) state_next = S_BP;
      S_BP:      if (be == 3'd5) state_next = S_DRAIN;
      S_BW: begin
        if ((ir == 2'd2) && (ic == 2'd3)) begin
          state_next = ((ci + 1'b1) < n) ? S_TH_GO : S_CMP;
        end
      end
      S_CMP:     if (cmp_end) state_next = S_DRAIN;
      S_SKW:     if (skw_end) state_next = S_DRAIN;
      S_DRAIN: begin
        if (!v1 && !pv) begin
          case (dmode)
            MD_BUILD: state_next = S_BW;
            MD_COMP: begin
              if ((li + 1'b1) < n) state_next = S_CMP;
              else if (first)      state_next = S_COL;
              else                 state_next = S_SKW;
            end
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_COL:     state_next = col_ok ? S_CMP : S_EMIT;
      S_EMIT: begin
        if (er == 3'd5) begin
          state_next = (jc == 3'(NCOLS - 1)) ? S_IDLE : S_COL;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    cgo  = (state == S_TH_GO) || (state == S_AL_GO);
    iss  = (state == S_BP) || (state == S_CMP) || (state == S_SKW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // link stores (no reset, written before read)
  always_ff @(posedge clk) begin
    if (accept && !cnt_full) begin
      la_mem[cnt[LW-1:0]] <= {link_length, link_offset};
      lt_mem[cnt[LW-1:0]] <= {link_twist, joint_angle};
    end
  end

  // counters and control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      n     <= '0;
      ci    <= '0;
      li    <= '0;
      jc    <= '0;
      er    <= '0;
      be    <= '0;
      ir    <= '0;
      ic    <= '0;
      ik    <= '0;
      bank  <= 1'b0;
      pid   <= 1'b0;
      first <= 1'b0;
      zcol  <= 1'b0;
      dmode <= MD_BUILD;
    end else begin
      if (iss) dmode <= imode;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_link) begin
              n   <= cnt_full ? cnt : cnt + 1'b1;
              cnt <= '0;
              ci  <= '0;
            end else if (!cnt_full) begin
              cnt <= cnt + 1'b1;
            end
          end
          ir <= '0; ic <= '0; ik <= '0; be <= '0; er <= '0;
        end
        S_BP: be <= be + 3'd1;
        S_BW: begin
          if (ic == 2'd3) begin
            ic <= '0;
            if (ir == 2'd2) begin
              ir    <= '0;
              ci    <= ci + 1'b1;
              li    <= '0;
              pid   <= 1'b1;
              first <= 1'b1;
            end else begin
              ir <= ir + 2'd1;
            end
          end else begin
            ic <= ic + 2'd1;
          end
        end
        S_CMP: begin
          if (klast_hit) begin
            ik <= '0;
            if (ic == 2'd3) begin
              ic <= '0;
              ir <= ir + 2'd1;
            end else begin
              ic <= ic + 2'd1;
            end
          end else begin
            ik <= ik + 2'd1;
          end
        end
        S_SKW: begin
          if (ik == 2'd2) begin
            ik <= '0;
            ir <= ir + 2'd1;
          end else begin
            ik <= ik + 2'd1;
          end
        end
        S_DRAIN: begin
          ir <= '0; ic <= '0; ik <= '0; be <= '0; er <= '0;
          if (!v1 && !pv && (dmode == MD_COMP)) begin
            bank <= ~bank;
            pid  <= 1'b0;
            li   <= li + 1'b1;
            if (!((li + 1'b1) < n) && first) begin
              first <= 1'b0;
              jc    <= '0;
            end
          end
        end
        S_COL: begin
          ir <= '0; ic <= '0; ik <= '0; be <= '0; er <= '0;
          zcol <= !col_ok;
          if (col_ok) begin
            pid <= 1'b1;
            li  <= '0;
          end
        end
        S_EMIT: begin
          if (er == 3'd5) begin
            er <= '0;
            jc <= jc + 3'd1;
          end else begin
            er <= er + 3'd1;
          end
        end
        default: begin
          ir <= '0; ic <= '0; ik <= '0; be <= '0; er <= '0;
        end
      endcase
    end
  end

  // CORDIC capture
  always_ff @(posedge clk) begin
    if ((state == S_TH_WAIT) && cdone) begin
      s_r <= DW'(csin);
      c_r <= DW'(ccos);
    end
    if ((state == S_AL_WAIT) && cdone) begin
      sa_r <= DW'(csin);
      ca_r <= DW'(ccos);
    end
  end

  // ---------------- result output ----------------
  always_comb begin
    if (zcol)               ev = '0;
    else if (er < 3'd3)     ev = pm_rd;
    else                    ev = sk[2'(er - 3'd3)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_EMIT);
    end
    row_index    <= er;
    column_index <= jc;
    last_entry   <= (jc == 3'(NCOLS - 1)) && (er == 3'(NROWS - 1));
    if (ev > OUT_MAX)      entry_value <= OUT_MAX[23:0];
    else if (ev < OUT_MIN) entry_value <= OUT_MIN[23:0];
    else                   entry_value <= ev[23:0];
  end

  // ---------------- checks ----------------
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_entry) |-> (row_index == 3'd5) && (column_index == 3'd6))
    else $error("last_entry not on final Jacobian entry");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && last_link))
    else $error("run began without a last link request");

  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |=> strobe)
    else $error("output row without strobe");

endmodule

/* tb/sv/dh_chain_jacobian_test.sv */
// Self-checking testbench for dh_chain_jacobian: links are sent one per request,
// each chain's 42 Jacobian entries are predicted in fixed point and compared.
// Depends on dhj_pkg and the dh_chain_jacobian RTL.
`timescale 1ns / 1ps

module dh_chain_jacobian_test;
  import dhj_pkg::*;

  localparam int LINK_CAP   = 8;
  localparam int JOINT_CNT  = 7;
  localparam int IDLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [23:0] val;
    logic               lst;
  } jac_entry_t;

  // Homogeneous transform: 3x4 block plus the bottom-right w term.
  typedef struct {
    longint m[3][4];
    longint w;
  } xform_t;

  // ---------------------------------------------------------------------
  // Scoreboard: holds its own copy of the stored chain and the queue of
  // Jacobian entries still to come out.
  // ---------------------------------------------------------------------
  class jacobian_board;
    logic signed [17:0] st_len[LINK_CAP], st_off[LINK_CAP];
    logic signed [17:0] st_twist[LINK_CAP], st_ang[LINK_CAP];
    int         n_stored;
    jac_entry_t pending[$];
    int         errors;

    function new();
      n_stored = 0;
      errors   = 0;
    endfunction

    // Q20 round-half-up: add half an LSB, then shift right (SV >>> on longint is floor).
    function longint rq(longint v);
      return (v + 64'sd524288) >>> FRAC;
    endfunction

    function void sincos(longint ang15, output longint s, output longint c);
      longint z, x, y, dx, dy;
      longint atab[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                           8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
                           8, 4, 2};
      bit flip;
      z = ang15 * 32; x = 636751; y = 0; flip = 0;
      if (z > 1647099) begin z -= 3294199; flip = 1; end
      else if (z < -1647099) begin z += 3294199; flip = 1; end
      for (int i = 0; i < 20; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin x -= dx; y += dy; z -= atab[i]; end
        else begin x += dx; y -= dy; z += atab[i]; end
      end
      if (flip) begin x = -x; y = -y; end
      s = y; c = x;
    endfunction

    function xform_t unit_xf();
      xform_t t;
      foreach (t.m[r, c]) t.m[r][c] = 0;
      t.m[0][0] = 1 << FRAC; t.m[1][1] = 1 << FRAC; t.m[2][2] = 1 << FRAC;
      t.w = 1;
      return t;
    endfunction

    function xform_t chain_mul(xform_t a, xform_t b);
      xform_t t;
      longint acc;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += a.m[r][k] * b.m[k][c];
          t.m[r][c] = rq(acc);
        end
        t.m[r][3] += a.m[r][3] * b.w;
      end
      t.w = a.w * b.w;
      return t;
    endfunction

    function void link_xf(int i, output xform_t tf, output xform_t dtf);
      longint a, d, al, th, s, c, sa, ca;
      a  = longint'(st_len[i]) * 16;
      d  = longint'(st_off[i]) * 16;
      al = st_twist[i];
      th = (i < JOINT_CNT) ? longint'(st_ang[i]) : 0;
      sincos(th, s, c);
      sincos(al, sa, ca);
      foreach (tf.m[r, k]) begin tf.m[r][k] = 0; dtf.m[r][k] = 0; end
      tf.m[0][0] = c;           tf.m[0][1] = -s;         tf.m[0][3] = a;
      tf.m[1][0] = rq(s * ca);  tf.m[1][1] = rq(c * ca);
      tf.m[1][2] = -sa;         tf.m[1][3] = -rq(d * sa);
      tf.m[2][0] = rq(s * sa);  tf.m[2][1] = rq(c * sa);
      tf.m[2][2] = ca;          tf.m[2][3] = rq(d * ca);
      tf.w = 1;
      dtf.m[0][0] = -s;         dtf.m[0][1] = -c;
      dtf.m[1][0] = rq(c * ca); dtf.m[1][1] = -rq(s * ca);
      dtf.m[2][0] = rq(c * sa); dtf.m[2][1] = -rq(s * sa);
      dtf.w = 0;
    endfunction

    function logic signed [23:0] clip24(longint v);
      if (v > 8388607) return 24'sd8388607;
      if (v < -8388608) return -24'sd8388608;
      return v[23:0];
    endfunction

    // Accepted link request; a last link expands into 42 expected entries.
    function void note_link(logic signed [17:0] ang, logic signed [17:0] len,
                            logic signed [17:0] off, logic signed [17:0] tw,
                            logic lst);
      xform_t tf[LINK_CAP], dtf[LINK_CAP], prod;
      longint rot[3][3], colv[6], w21, w02, w10;
      jac_entry_t e;
      int n;
      if (n_stored < LINK_CAP) begin   // full table drops the link
        st_ang[n_stored] = ang; st_len[n_stored] = len;
        st_off[n_stored] = off; st_twist[n_stored] = tw;
        n_stored++;
      end
      if (!lst) return;
      n = n_stored;
      n_stored = 0;
      prod = unit_xf();
      for (int i = 0; i < n; i++) begin
        link_xf(i, tf[i], dtf[i]);
        prod = chain_mul(prod, tf[i]);
      end
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++) rot[r][k] = prod.m[r][k];
      for (int j = 0; j < NCOLS; j++) begin
        for (int r = 0; r < 6; r++) colv[r] = 0;
        // columns for absent joints stay zero
        if (j < n && j < JOINT_CNT) begin
          prod = unit_xf();
          for (int i = 0; i < n; i++)
            prod = chain_mul(prod, (i == j) ? dtf[i] : tf[i]);
          w21 = 0; w02 = 0; w10 = 0;
          for (int k = 0; k < 3; k++) begin
            w21 += prod.m[2][k] * rot[1][k];
            w02 += prod.m[0][k] * rot[2][k];
            w10 += prod.m[1][k] * rot[0][k];
          end
          colv[0] = prod.m[0][3]; colv[1] = prod.m[1][3]; colv[2] = prod.m[2][3];
          colv[3] = rq(w21); colv[4] = rq(w02); colv[5] = rq(w10);
        end
        for (int r = 0; r < NROWS; r++) begin
          e.row = 3'(r); e.col = 3'(j); e.val = clip24(colv[r]);
          e.lst = (j == NCOLS - 1 && r == NROWS - 1);
          pending = {pending, e};
        end
      end
    endfunction

    function void check_entry(jac_entry_t got);
      jac_entry_t exp_e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected entry r%0d c%0d v%0d", got.row,
                                   got.col, got.val);
        return;
      end
      exp_e = pending.pop_front();
      if (got.row !== exp_e.row || got.col !== exp_e.col ||
          got.val !== exp_e.val || got.lst !== exp_e.lst) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp r%0d c%0d v%0d l%0d, got r%0d c%0d v%0d l%0d",
                   exp_e.row, exp_e.col, exp_e.val, exp_e.lst,
                   got.row, got.col, got.val, got.lst);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0, last_link = 0;
  logic signed [17:0] joint_angle = 0, link_length = 0, link_offset = 0, link_twist = 0;
  logic busy, strobe, last_entry;
  logic [2:0] row_index, column_index;
  logic signed [23:0] entry_value;

  jacobian_board board;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  dh_chain_jacobian u_top (.*);

  // Result side: the block cannot be stalled, so just sample each strobe.
  always @(posedge clk) begin
    jac_entry_t got;
    if (!rst && strobe) begin
      got.row = row_index; got.col = column_index;
      got.val = entry_value; got.lst = last_entry;
      board.check_entry(got);
    end
  end

  // Watchdog on cycles with no request and no result accepted.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // No gap half the time, else mostly short gaps, occasionally a long one.
  // start only drops when there is a real gap.
  task automatic sender_gap();
    int g;
    g = ($urandom_range(0, 9) < 5) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // One link request; returns once it has been accepted.
  task automatic send_link(logic signed [17:0] ang, logic signed [17:0] len,
                           logic signed [17:0] off, logic signed [17:0] tw,
                           logic lst);
    start <= 1; joint_angle <= ang; link_length <= len;
    link_offset <= off; link_twist <= tw; last_link <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_link(ang, len, off, tw, lst);
    sender_gap();
  endtask

  function automatic logic signed [17:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return 18'sh1FFFF;
      1: return 18'sh20000;
      2: return 18'($urandom_range(0, 4000) - 2000);
      default: return 18'($urandom());
    endcase
  endfunction

  task automatic send_chain(int nlinks);
    for (int i = 0; i < nlinks; i++)
      send_link(rnd_field(), rnd_field(), rnd_field(), rnd_field(), i == nlinks - 1);
  endtask

  task automatic wait_drain();
    start <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: single link at the field extremes, positive and negative.
    send_link(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 1'b1);
    send_link(18'sh20000, 18'sh20000, 18'sh20000, 18'sh20000, 1'b1);
    // Zero angles/lengths; angles near +-pi/2 and pi.
    send_link('0, '0, '0, '0, 1'b0);
    send_link(18'sd51472, 18'sd65536, '0, -18'sd51471, 1'b0);
    send_link(18'sd102944, '0, 18'sd32768, 18'sd51471, 1'b1);
    // Full chain of 8: last link is a fixed link (angle ignored).
    for (int i = 0; i < 8; i++)
      send_link(18'(12000 * i - 40000), 18'sd6000, -18'sd3000,
                (i[0]) ? 18'sd51472 : 18'sd0, i == 7);
    // Table full: two extra links dropped, the second marked last.
    for (int i = 0; i < 10; i++)
      send_link(rnd_field(), rnd_field(), rnd_field(), rnd_field(), i == 9);
    // Sender holds off until everything is out.
    wait_drain();

    sent = 0;
    while (sent < 300) begin
      int nl;
      nl = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 10);
      send_chain(nl);
      sent += nl;
      if ($urandom_range(0, 9) == 0) wait_drain();
    end

    wait_drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

/* sim.f */
rtl/dhj_pkg.sv
rtl/dhj_cordic.sv
rtl/dhj_mac.sv
rtl/dh_chain_jacobian.sv
tb/sv/dh_chain_jacobian_test.sv
